// ===== rtl/fpt_pkg.sv =====
// Shared constants and types for the fixed-point amount to decimal text core.
// Used by fpt_dabble, fpt_emit and the top level; depends on nothing.
`default_nettype none
package fpt_pkg;
  localparam int AmountBits  = 64;
  localparam int NumDigits   = 20;
  localparam int BcdBits     = NumDigits * 4;
  localparam int CntW        = $clog2(AmountBits + 1);
  localparam int PosW        = $clog2(NumDigits);
  localparam logic [7:0] MaxDecimals = 8'd19;
  localparam logic [PosW-1:0] TopPos = PosW'(NumDigits - 1);
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharNone    = 8'h00;

  typedef struct packed {
    logic               done;
    logic [BcdBits-1:0] bcd;
  } conv_result_t;
endpackage
`default_nettype wire

// ===== rtl/fpt_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one amount bit per cycle.
// Depends on fpt_pkg.
`default_nettype none
module fpt_dabble (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [fpt_pkg::AmountBits-1:0]   amount_i,
  output fpt_pkg::conv_result_t                 result_o
);
  logic [fpt_pkg::AmountBits-1:0] bin_q, bin_d;
  logic [fpt_pkg::BcdBits-1:0]    bcd_q, bcd_d, adj;
  logic [fpt_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           done_q, done_d;

  always_comb begin
    for (int k = 0; k < fpt_pkg::NumDigits; k++) begin
      if (bcd_q[k*4 +: 4] >= 4'd5) begin
        adj[k*4 +: 4] = bcd_q[k*4 +: 4] + 4'd3;
      end else begin
        adj[k*4 +: 4] = bcd_q[k*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = amount_i;
      bcd_d = '0;
      cnt_d = fpt_pkg::CntW'(fpt_pkg::AmountBits);
    end else if (cnt_q != '0) begin
      bcd_d  = {adj[fpt_pkg::BcdBits-2:0], bin_q[fpt_pkg::AmountBits-1]};
      bin_d  = bin_q << 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == fpt_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign result_o.done = done_q;
  assign result_o.bcd  = bcd_q;
endmodule
`default_nettype wire

// ===== rtl/fpt_emit.sv =====
// Character sequencer: walks the BCD digits from the top, one digit per cycle apart from the '.' step,
// skipping leading zeros and trimming trailing fraction zeros. Depends on fpt_pkg.
`default_nettype none
module fpt_emit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [7:0]            decimals_i,
  input  wire fpt_pkg::conv_result_t conv_i,
  output logic                       busy_o,
  output logic                       strobe_o,
  output logic [7:0]                 char_code_o,
  output logic                       error_o,
  output logic                       last_o
);
  typedef enum logic [2:0] {S_IDLE, S_WAIT, S_INT, S_DOT, S_FRAC} state_e;

  state_e                      state_q;
  logic [fpt_pkg::BcdBits-1:0] sr_q;
  logic [fpt_pkg::PosW-1:0]    pos_q, dec_q;
  logic                        lead_q;
  logic                        strobe_q, error_q, last_q;
  logic [7:0]                  char_q;
  logic [3:0]                  top;
  logic                        rest_zero;
  logic [7:0]                  digit_char;

  assign top        = sr_q[fpt_pkg::BcdBits-1 -: 4];
  assign rest_zero  = (sr_q[fpt_pkg::BcdBits-5:0] == '0);
  assign digit_char = fpt_pkg::CharZero + {4'b0, top};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sr_q     <= '0;
      pos_q    <= '0;
      dec_q    <= '0;
      lead_q   <= 1'b0;
      strobe_q <= 1'b0;
      error_q  <= 1'b0;
      last_q   <= 1'b0;
      char_q   <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (decimals_i > fpt_pkg::MaxDecimals) begin
              strobe_q <= 1'b1;
              error_q  <= 1'b1;
              last_q   <= 1'b1;
              char_q   <= fpt_pkg::CharNone;
            end else begin
              state_q <= S_WAIT;
              dec_q   <= decimals_i[fpt_pkg::PosW-1:0];
              pos_q   <= fpt_pkg::TopPos;
              lead_q  <= 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (conv_i.done) begin
            sr_q    <= conv_i.bcd;
            state_q <= S_INT;
          end
        end
        S_INT: begin
          sr_q <= sr_q << 4;
          if (lead_q && (pos_q > dec_q) && (top == 4'd0)) begin
            pos_q <= pos_q - 1'b1;
          end else begin
            lead_q   <= 1'b0;
            strobe_q <= 1'b1;
            error_q  <= 1'b0;
            char_q   <= digit_char;
            if (pos_q == dec_q) begin
              last_q  <= rest_zero;
              state_q <= rest_zero ? S_IDLE : S_DOT;
            end else begin
              last_q <= 1'b0;
              pos_q  <= pos_q - 1'b1;
            end
          end
        end
        S_DOT: begin
          strobe_q <= 1'b1;
          error_q  <= 1'b0;
          last_q   <= 1'b0;
          char_q   <= fpt_pkg::CharDot;
          state_q  <= S_FRAC;
        end
        S_FRAC: begin
          sr_q     <= sr_q << 4;
          strobe_q <= 1'b1;
          error_q  <= 1'b0;
          last_q   <= rest_zero;
          char_q   <= digit_char;
          if (rest_zero) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign error_o     = error_q;
  assign last_o      = last_q;
endmodule
`default_nettype wire

// ===== rtl/fixed_point_amount_to_decimal_text_core.sv =====
// Top level: fixed-point amount to ASCII decimal text, one character per word.
// Depends on fpt_pkg, fpt_dabble and fpt_emit.
//
//   channel  | handshake             | words
//   ---------+-----------------------+-------------------------------------
//   command  | start / busy          | amount_i, decimals_i
//   result   | strobe_o (no stall)   | char_code_o, error_o, last_o
//
// An amount first passes through the bit-serial converter; the sequencer then takes
// each integral digit or skipped leading zero from digit 19 down, then '.' and
// the kept fraction digits, if any.
// A count above 19 gives its single error word on the cycle after start, busy low.
// busy is registered: it rises after acceptance and falls as the last word reaches the result ports; no stalls.
// Reset is asynchronous, active low, and returns the core to idle.
`default_nettype none
module fixed_point_amount_to_decimal_text_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [fpt_pkg::AmountBits-1:0] amount_i,
  input  wire logic [7:0]                     decimals_i,
  output logic                                strobe_o,
  output logic [7:0]                          char_code_o,
  output logic                                error_o,
  output logic                                last_o
);
  fpt_pkg::conv_result_t conv;
  logic                  accept;
  logic                  conv_start;

  assign accept     = start && !busy;
  assign conv_start = accept && (decimals_i <= fpt_pkg::MaxDecimals);

  fpt_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .amount_i (amount_i),
    .result_o (conv)
  );

  fpt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .decimals_i  (decimals_i),
    .conv_i      (conv),
    .busy_o      (busy),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );
endmodule
`default_nettype wire

// ===== test/fpt_text_checker.sv =====
// Checker for the fixed-point amount to decimal text core: watches the command
// and result channels, renders each accepted amount into its expected words.
// Depends on fpt_pkg.
module fpt_text_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic [fpt_pkg::AmountBits-1:0] amount_i,
  input  wire logic [7:0]                     decimals_i,
  input  wire logic                           strobe_i,
  input  wire logic [7:0]                     char_code_i,
  input  wire logic                           error_i,
  input  wire logic                           last_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  amounts_o,
  output int                                  overflows_o,
  output int                                  words_o
);
  typedef struct packed {
    logic [7:0] code;
    logic       err;
    logic       tail;
  } text_word_t;

  text_word_t char_queue[$];

  function automatic void render_amount(input logic [fpt_pkg::AmountBits-1:0] amount,
                                        input logic [7:0] places);
    logic [63:0] scale;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [7:0]  text[$];
    logic [7:0]  frac_digit[fpt_pkg::NumDigits];
    int          keep;
    if (places > fpt_pkg::MaxDecimals) begin
      char_queue.push_back('{fpt_pkg::CharNone, 1'b1, 1'b1});
      return;
    end
    scale = 64'd1;
    for (int i = 0; i < int'(places); i++) scale = scale * 64'd10;
    whole = 64'(amount) / scale;
    frac  = 64'(amount) % scale;
    do begin
      text.push_front(fpt_pkg::CharZero + 8'(whole % 64'd10));
      whole = whole / 64'd10;
    end while (whole != 64'd0);
    if (frac != 64'd0) begin
      text.push_back(fpt_pkg::CharDot);
      for (int i = int'(places) - 1; i >= 0; i--) begin
        frac_digit[i] = fpt_pkg::CharZero + 8'(frac % 64'd10);
        frac = frac / 64'd10;
      end
      // drop trailing zeros, keep leading ones
      keep = int'(places);
      while (keep > 1 && frac_digit[keep-1] == fpt_pkg::CharZero) keep--;
      for (int i = 0; i < keep; i++) text.push_back(frac_digit[i]);
    end
    foreach (text[i]) char_queue.push_back('{text[i], 1'b0, i == text.size() - 1});
  endfunction

  always @(posedge clk_i) begin
    text_word_t want;
    if (rst_ni) begin
      if (strobe_i) begin
        words_o++;
        if (char_queue.size() == 0) begin
          $error("unexpected word: char_code %h error %b last %b",
                 char_code_i, error_i, last_i);
          fail_count_o++;
        end else begin
          want = char_queue.pop_front();
          if (char_code_i !== want.code) begin
            $error("char_code mismatch: expected %h, actual %h", want.code, char_code_i);
            fail_count_o++;
          end
          if (error_i !== want.err) begin
            $error("error mismatch: expected %b, actual %b", want.err, error_i);
            fail_count_o++;
          end
          if (last_i !== want.tail) begin
            $error("last mismatch: expected %b, actual %b", want.tail, last_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        amounts_o++;
        if (decimals_i > fpt_pkg::MaxDecimals) overflows_o++;
        render_amount(amount_i, decimals_i);
      end
    end
    pending_o = char_queue.size();
  end
endmodule

// ===== test/testbench.sv =====
// Top of the fixed-point amount to decimal text testbench: clock, reset and
// command stimulus in three idling phases; depends on the core, fpt_pkg and
// fpt_text_checker, which does all prediction and comparison.
module testbench;
  logic                           clk_i    = 1'b0;
  logic                           rst_ni   = 1'b0;
  logic                           start    = 1'b0;
  logic [fpt_pkg::AmountBits-1:0] amount   = '0;
  logic [7:0]                     decimals = 8'd0;
  wire logic                      busy;
  wire logic                      strobe;
  wire logic [7:0]                char_code;
  wire logic                      error_flag;
  wire logic                      last_flag;
  int                             fail_count;
  int                             pending;
  int                             amounts;
  int                             overflows;
  int                             words;
  int                             idle_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fixed_point_amount_to_decimal_text_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .amount_i    (amount),
    .decimals_i  (decimals),
    .strobe_o    (strobe),
    .char_code_o (char_code),
    .error_o     (error_flag),
    .last_o      (last_flag)
  );

  fpt_text_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .amount_i     (amount),
    .decimals_i   (decimals),
    .strobe_i     (strobe),
    .char_code_i  (char_code),
    .error_i      (error_flag),
    .last_i       (last_flag),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .amounts_o    (amounts),
    .overflows_o  (overflows),
    .words_o      (words)
  );

  task automatic send_amount(input logic [fpt_pkg::AmountBits-1:0] amt,
                             input logic [7:0] places);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      // sometimes let the core go idle first so the gap lands after busy drops
      if ($urandom_range(1)) do @(posedge clk_i); while (busy);
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    amount   <= amt;
    decimals <= places;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random(input int count);
    logic [fpt_pkg::AmountBits-1:0] amt;
    logic [63:0]                    scale;
    logic [7:0]                     places;
    int                             kind;
    repeat (count) begin
      kind   = $urandom_range(9);
      amt    = {$urandom, $urandom};
      places = 8'($urandom_range(19));
      if (kind == 0) begin
        places = 8'($urandom_range(255, 20));
      end else if (kind == 1) begin
        amt = fpt_pkg::AmountBits'($urandom_range(999));
      end else if (kind <= 4) begin
        // trailing zeros: exercise trimming and zero fractions
        scale = 64'd1;
        repeat ($urandom_range(19)) scale = scale * 64'd10;
        amt = amt - amt % scale;
      end
      send_amount(amt, places);
    end
  endtask

  initial begin
    #5_000_000;
    $display("fixed_point_amount_to_decimal_text_core verification failed");
    $finish;
  end

  initial begin
    idle_pct = 14;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_amount(64'd0, 8'd0);
    send_amount(64'd0, 8'd19);
    send_amount('1, 8'd0);
    send_amount('1, 8'd1);
    send_amount('1, 8'd19);
    send_amount(64'd1, 8'd19);
    send_amount(64'd10_000_000_000_000_000_000, 8'd19);
    send_amount(64'd1_000_000_000_000_000_000, 8'd18);
    send_amount(64'h8000_0000_0000_0000, 8'd18);
    send_amount(64'd1230, 8'd3);
    send_amount(64'd1000, 8'd3);
    send_amount(64'd5, 8'd3);
    send_amount(64'd105, 8'd2);
    send_amount(64'd1, 8'd1);
    send_amount(64'd123_456_789, 8'd9);
    send_amount(64'd9_999_999_999_999_999_999, 8'd19);
    send_amount(64'd20, 8'd20);
    send_amount(64'd0, 8'd255);
    send_amount('1, 8'd128);
    send_amount(64'd12, 8'd0);

    send_random(50);
    idle_pct = 87;
    send_random(50);
    idle_pct = 0;
    send_random(50);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (pending != 0) $error("%0d expected words never arrived", pending);
    $display("ran %0d amounts, %0d of them with too many decimal places;", amounts, overflows);
    $display("compared %0d result words over three idling phases", words);
    if (fail_count == 0 && pending == 0) begin
      $display("fixed_point_amount_to_decimal_text_core verification clean");
    end else begin
      $display("fixed_point_amount_to_decimal_text_core verification failed");
    end
    $finish;
  end
endmodule
